// ===== rtl/core/fpbf_pkg.sv =====
// shared types, sizes and codes of the fixed-partition best-fit allocator
// no dependencies; used by fpbf_ctrl, fpbf_dp and the top level

package fpbf_pkg;

    localparam int NUM_PARTS     = 4;
    localparam int MAX_PARTS     = 4;
    localparam int NUM_PROCS     = 16;
    localparam int SIZE_BITS     = 16;
    localparam int FRAG_BITS     = SIZE_BITS + 2;
    localparam int PART_BITS     = 2;
    localparam int PROC_IDX_BITS = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int PID_BITS      = 4;
    localparam int REQ_BITS      = 2;
    localparam int STATUS_BITS   = 3;
    localparam int PNUM_BITS     = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MEMORY_SIZE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PART_SIZE_0 = 3'd1;

    // request kinds
    localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_DELETE = 2'd1;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_INTFRAG  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_EXTFRAG  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NOFIT    = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_DELETED  = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_ABSENT   = 3'd6;
    localparam logic [STATUS_BITS-1:0] ST_REPORT   = 3'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DECIDE
    } fpbf_state_t;

    typedef struct packed {
        logic                 load;
        logic                 step;
        logic                 commit;
        logic [PART_BITS-1:0] idx;
    } fpbf_cmd_t;

    typedef struct packed {
        logic out_free;
    } fpbf_stat_t;

endpackage

// ===== rtl/core/fixed_partition_best_fit_allocator.sv =====
// top level of the fixed-partition best-fit allocator
// depends on fpbf_pkg, fpbf_ctrl and fpbf_dp
//
// usage:
//  - config port: cfg_we/cfg_index/cfg_data, index 0 is the memory size,
//    indexes 1 to 4 are the four partition sizes; other indexes are dropped.
//    write only while the block is idle
//  - input channel: in_valid/in_stall with req_type, process_id, process_size;
//    a transfer happens when in_valid is high and in_stall is low
//  - output channel: out_valid/out_stall with status, partition_number,
//    unused_memory, total_internal_frag; one result per input item
//  - sequence: after the input transfer the item walks the partitions, one per
//    walk step, and a decision step then loads the result register
//  - the walk of the four partitions runs through a single compare/add unit, so
//    no new item is taken during a walk; the next item is taken in the decision
//    cycle of the current one, once the result register is free
//  - the result register decouples the sides: when the receiver stalls, the
//    result holds and the next item is still taken and walked; its decision
//    waits until the held result has been transferred
//  - reset clears config registers, all partitions and processes, and the
//    output valid

module fixed_partition_best_fit_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [fpbf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [fpbf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fpbf_pkg::REQ_BITS-1:0]       req_type,
    input  logic [fpbf_pkg::PID_BITS-1:0]       process_id,
    input  logic [fpbf_pkg::SIZE_BITS-1:0]      process_size,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fpbf_pkg::STATUS_BITS-1:0]    status,
    output logic [fpbf_pkg::PNUM_BITS-1:0]      partition_number,
    output logic [fpbf_pkg::SIZE_BITS-1:0]      unused_memory,
    output logic [fpbf_pkg::FRAG_BITS-1:0]      total_internal_frag
);

    // commands from controller, status back from datapath
    fpbf_pkg::fpbf_cmd_t  cmd;
    fpbf_pkg::fpbf_stat_t stat;

    // sequencer: idle, walk over partitions, decide
    fpbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // state, walk accumulators and result register
    fpbf_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .req_type            (req_type),
        .process_id          (process_id),
        .process_size        (process_size),
        .out_stall           (out_stall),
        .out_valid           (out_valid),
        .status              (status),
        .partition_number    (partition_number),
        .unused_memory       (unused_memory),
        .total_internal_frag (total_internal_frag),
        .cmd                 (cmd),
        .stat                (stat)
    );

endmodule

// ===== rtl/core/fpbf_ctrl.sv =====
// controller of the allocator: accept, partition walk, decision
// depends on fpbf_pkg

module fpbf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fpbf_pkg::fpbf_stat_t stat,
    output fpbf_pkg::fpbf_cmd_t  cmd
);

    fpbf_pkg::fpbf_state_t state_reg;
    fpbf_pkg::fpbf_state_t state_next;
    logic [fpbf_pkg::PART_BITS-1:0] idx_reg;
    logic [fpbf_pkg::PART_BITS-1:0] idx_next;
    logic last_part;
    logic take;

    assign last_part = (idx_reg == fpbf_pkg::PART_BITS'(fpbf_pkg::NUM_PARTS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            fpbf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fpbf_pkg::S_WALK;
                    idx_next   = '0;
                end
            end
            fpbf_pkg::S_WALK:
            begin
                if (last_part)
                begin
                    state_next = fpbf_pkg::S_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            fpbf_pkg::S_DECIDE:
            begin
                if (stat.out_free)
                begin
                    idx_next = '0;
                    if (in_valid)
                    begin
                        state_next = fpbf_pkg::S_WALK;
                    end
                    else
                    begin
                        state_next = fpbf_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = fpbf_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        take       = 1'b0;
        cmd.step   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            fpbf_pkg::S_IDLE:
            begin
                take = 1'b1;
            end
            fpbf_pkg::S_WALK:
            begin
                cmd.step = 1'b1;
            end
            fpbf_pkg::S_DECIDE:
            begin
                take       = stat.out_free;
                cmd.commit = stat.out_free;
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
        in_stall = !take;
        cmd.load = take && in_valid;
        cmd.idx  = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpbf_pkg::S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== rtl/core/fpbf_dp.sv =====
// datapath of the allocator: config registers, partition and process state,
// walk accumulators and the result register; depends on fpbf_pkg

module fpbf_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [fpbf_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [fpbf_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic [fpbf_pkg::REQ_BITS-1:0]          req_type,
    input  logic [fpbf_pkg::PID_BITS-1:0]          process_id,
    input  logic [fpbf_pkg::SIZE_BITS-1:0]         process_size,
    input  logic                                   out_stall,
    output logic                                   out_valid,
    output logic [fpbf_pkg::STATUS_BITS-1:0]       status,
    output logic [fpbf_pkg::PNUM_BITS-1:0]         partition_number,
    output logic [fpbf_pkg::SIZE_BITS-1:0]         unused_memory,
    output logic [fpbf_pkg::FRAG_BITS-1:0]         total_internal_frag,
    input  fpbf_pkg::fpbf_cmd_t                    cmd,
    output fpbf_pkg::fpbf_stat_t                   stat
);

    localparam int SB = fpbf_pkg::SIZE_BITS;
    localparam int FB = fpbf_pkg::FRAG_BITS;
    localparam int PB = fpbf_pkg::PART_BITS;
    localparam int MP = fpbf_pkg::MAX_PARTS;

    // configuration
    logic [SB-1:0] memory_size_reg;
    logic [SB-1:0] part_size_reg [MP];

    // allocation state
    logic          part_occupied_reg [MP];
    logic [SB-1:0] part_leftover_reg [MP];
    logic [fpbf_pkg::NUM_PROCS-1:0] proc_present_reg;
    logic [PB-1:0] proc_partition_reg [fpbf_pkg::NUM_PROCS];

    // current item
    logic [fpbf_pkg::REQ_BITS-1:0] req_reg;
    logic [fpbf_pkg::PID_BITS-1:0] pid_reg;
    logic [SB-1:0]                 psize_reg;

    // walk accumulators
    logic [SB-1:0] rem_reg,   rem_next;
    logic          found_reg, found_next;
    logic          infrag_reg, infrag_next;
    logic [PB-1:0] best_reg,  best_next;
    logic [SB-1:0] best_size_reg, best_size_next;
    logic [FB-1:0] exsum_reg, exsum_next;
    logic [FB-1:0] total_reg, total_next;

    // result register
    logic                                out_valid_reg;
    logic [fpbf_pkg::STATUS_BITS-1:0]    status_reg,  status_next;
    logic [fpbf_pkg::PNUM_BITS-1:0]      pnum_reg,    pnum_next;
    logic [SB-1:0]                       unused_reg,  unused_next;
    logic [FB-1:0]                       frag_reg,    frag_next;

    logic [SB-1:0] cur_size;
    logic [SB-1:0] cur_left;
    logic          cur_occ;
    logic          cur_en;
    logic          pid_ok;
    logic [fpbf_pkg::PROC_IDX_BITS-1:0] pidx;
    logic          do_insert;
    logic          do_delete;
    logic [PB-1:0] del_part;

    assign cur_size = part_size_reg[cmd.idx];
    assign cur_left = part_leftover_reg[cmd.idx];
    assign cur_occ  = part_occupied_reg[cmd.idx];
    assign cur_en   = (cur_size <= rem_reg);
    assign pid_ok   = (int'(pid_reg) < fpbf_pkg::NUM_PROCS);
    assign pidx     = fpbf_pkg::PROC_IDX_BITS'(pid_reg);
    assign del_part = proc_partition_reg[pidx];

    // one partition per step
    always_comb
    begin
        rem_next       = rem_reg;
        found_next     = found_reg;
        infrag_next    = infrag_reg;
        best_next      = best_reg;
        best_size_next = best_size_reg;
        exsum_next     = exsum_reg;
        total_next     = total_reg;
        if (cmd.load)
        begin
            rem_next    = memory_size_reg;
            found_next  = 1'b0;
            infrag_next = 1'b0;
            best_next   = '0;
            best_size_next = '0;
            exsum_next  = '0;
            total_next  = '0;
        end
        else if (cmd.step)
        begin
            if (cur_en)
            begin
                rem_next = rem_reg - cur_size;
            end
            if (cur_occ)
            begin
                total_next = total_reg + FB'(cur_left);
                if (cur_left >= psize_reg)
                begin
                    infrag_next = 1'b1;
                end
                else
                begin
                    exsum_next = exsum_reg + FB'(cur_left);
                end
            end
            else if (cur_en && cur_size >= psize_reg &&
                     (!found_reg || cur_size < best_size_reg))
            begin
                found_next     = 1'b1;
                best_next      = cmd.idx;
                best_size_next = cur_size;
            end
        end
    end

    // decision
    always_comb
    begin
        status_next = fpbf_pkg::ST_NOFIT;
        pnum_next   = '0;
        unused_next = '0;
        frag_next   = '0;
        do_insert   = 1'b0;
        do_delete   = 1'b0;
        case (req_reg)
            fpbf_pkg::REQ_INSERT:
            begin
                if (!pid_ok)
                begin
                    status_next = fpbf_pkg::ST_NOFIT;
                end
                else if (proc_present_reg[pidx])
                begin
                    status_next = fpbf_pkg::ST_PRESENT;
                    pnum_next   = fpbf_pkg::PNUM_BITS'(proc_partition_reg[pidx]) + 1'b1;
                end
                else if (found_reg)
                begin
                    status_next = fpbf_pkg::ST_INSERTED;
                    pnum_next   = fpbf_pkg::PNUM_BITS'(best_reg) + 1'b1;
                    do_insert   = 1'b1;
                end
                else if (infrag_reg)
                begin
                    status_next = fpbf_pkg::ST_INTFRAG;
                end
                else if (FB'(psize_reg) <= exsum_reg)
                begin
                    status_next = fpbf_pkg::ST_EXTFRAG;
                end
                else
                begin
                    status_next = fpbf_pkg::ST_NOFIT;
                end
            end
            fpbf_pkg::REQ_DELETE:
            begin
                if (!pid_ok || !proc_present_reg[pidx])
                begin
                    status_next = fpbf_pkg::ST_ABSENT;
                end
                else
                begin
                    status_next = fpbf_pkg::ST_DELETED;
                    pnum_next   = fpbf_pkg::PNUM_BITS'(del_part) + 1'b1;
                    do_delete   = 1'b1;
                end
            end
            default:
            begin
                // report, also for the unused request code
                status_next = fpbf_pkg::ST_REPORT;
                unused_next = rem_reg;
                frag_next   = total_reg;
            end
        endcase
    end

    assign stat.out_free = !out_valid_reg || !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_size_reg <= '0;
            for (int i = 0; i < MP; i++)
            begin
                part_size_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == fpbf_pkg::REG_MEMORY_SIZE)
            begin
                memory_size_reg <= SB'(cfg_data);
            end
            for (int i = 0; i < MP; i++)
            begin
                if (cfg_index == fpbf_pkg::REG_PART_SIZE_0 + fpbf_pkg::CFG_IDX_BITS'(i))
                begin
                    part_size_reg[i] <= SB'(cfg_data);
                end
            end
        end
    end

    // partition and process state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_present_reg <= '0;
            for (int i = 0; i < MP; i++)
            begin
                part_occupied_reg[i] <= 1'b0;
                part_leftover_reg[i] <= '0;
            end
            for (int j = 0; j < fpbf_pkg::NUM_PROCS; j++)
            begin
                proc_partition_reg[j] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (do_insert)
            begin
                part_occupied_reg[best_reg] <= 1'b1;
                part_leftover_reg[best_reg] <= best_size_reg - psize_reg;
                proc_present_reg[pidx]      <= 1'b1;
                proc_partition_reg[pidx]    <= best_reg;
            end
            else if (do_delete)
            begin
                part_occupied_reg[del_part] <= 1'b0;
                part_leftover_reg[del_part] <= '0;
                proc_present_reg[pidx]      <= 1'b0;
                proc_partition_reg[pidx]    <= '0;
            end
        end
    end

    // item and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            pid_reg   <= process_id;
            psize_reg <= process_size;
        end
        rem_reg       <= rem_next;
        found_reg     <= found_next;
        infrag_reg    <= infrag_next;
        best_reg      <= best_next;
        best_size_reg <= best_size_next;
        exsum_reg     <= exsum_next;
        total_reg     <= total_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= status_next;
            pnum_reg   <= pnum_next;
            unused_reg <= unused_next;
            frag_reg   <= frag_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign status              = status_reg;
    assign partition_number    = pnum_reg;
    assign unused_memory       = unused_reg;
    assign total_internal_frag = frag_reg;

    // a result is never written over one that is still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("commit while result register held");

    // the number of occupied partitions equals the number of present processes
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({part_occupied_reg[0], part_occupied_reg[1],
                    part_occupied_reg[2], part_occupied_reg[3]})
            == $countones(proc_present_reg))
        else $error("partition and process occupancy disagree");

    // a successful insert leaves its partition occupied
    a_insert_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && do_insert) |=> part_occupied_reg[$past(best_reg)])
        else $error("inserted partition not occupied");

    // only a report carries memory figures
    a_report_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != fpbf_pkg::ST_REPORT)
            |-> (unused_reg == '0 && frag_reg == '0))
        else $error("memory figures on a non-report result");

endmodule

// ===== tb/tb_fixed_partition_best_fit_allocator.sv =====
// self-checking bench for the fixed-partition best-fit allocator: directed and random requests,
// a behavioral allocator model in the bench, random idling on both channels
// depends on fpbf_pkg and fixed_partition_best_fit_allocator

module tb_fixed_partition_best_fit_allocator;

    import fpbf_pkg::*;

    // request kinds the package leaves unnamed
    localparam logic [REQ_BITS-1:0] REQ_REPORT = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_SPARE  = 2'd3;

    localparam int NUM_REGS       = 1 + MAX_PARTS;
    localparam int LAST_CFG_INDEX = (1 << CFG_IDX_BITS) - 1;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 135;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_PRINTED    = 50;

    typedef struct packed {
        logic [REQ_BITS-1:0]  req;
        logic [PID_BITS-1:0]  pid;
        logic [SIZE_BITS-1:0] size;
    } alloc_req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [PNUM_BITS-1:0]   pnum;
        logic [SIZE_BITS-1:0]   unused;
        logic [FRAG_BITS-1:0]   frag;
    } alloc_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [REQ_BITS-1:0]      req_type = '0;
    logic [PID_BITS-1:0]      process_id = '0;
    logic [SIZE_BITS-1:0]     process_size = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [STATUS_BITS-1:0]   status;
    logic [PNUM_BITS-1:0]     partition_number;
    logic [SIZE_BITS-1:0]     unused_memory;
    logic [FRAG_BITS-1:0]     total_internal_frag;

    // bench copy of the register file
    logic [SIZE_BITS-1:0] mem_cfg = '0;
    logic [SIZE_BITS-1:0] part_cfg [MAX_PARTS] = '{default: '0};

    // bench copy of the allocation state
    logic                 part_busy [MAX_PARTS] = '{default: 1'b0};
    logic [PID_BITS-1:0]  part_owner [MAX_PARTS] = '{default: '0};
    logic [SIZE_BITS-1:0] part_slack [MAX_PARTS] = '{default: '0};
    logic                 proc_here [NUM_PROCS] = '{default: 1'b0};
    logic [PART_BITS-1:0] proc_slot [NUM_PROCS] = '{default: '0};

    alloc_req_t    pending_requests [$];
    alloc_result_t expected_results [$];

    int n_queued    = 0;
    int n_taken     = 0;
    int n_results   = 0;
    int err_count   = 0;
    int in_gap      = 0;
    int out_gap     = 0;
    int in_idle_rate  = 0;
    int out_idle_rate = 0;
    int idle_cycles = 0;

    fixed_partition_best_fit_allocator dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .req_type            (req_type),
        .process_id          (process_id),
        .process_size        (process_size),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .partition_number    (partition_number),
        .unused_memory       (unused_memory),
        .total_internal_frag (total_internal_frag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // allocator model: enables follow the live registers on every request,
    // then insert / delete update the bench state and report reads it
    function automatic alloc_result_t predict_allocation(alloc_req_t rq);
        alloc_result_t        res;
        logic [SIZE_BITS-1:0] room;
        logic                 enabled [MAX_PARTS];
        logic                 found;
        logic                 covered;
        int unsigned          best;
        int unsigned          best_size;
        int unsigned          small_sum;
        int unsigned          frag_sum;
        res = '0;
        res.status = ST_NOFIT;
        room = mem_cfg;
        found = 1'b0;
        covered = 1'b0;
        best = 0;
        best_size = 0;
        small_sum = 0;
        frag_sum = 0;
        // carve partitions in index order out of what is left
        for (int i = 0; i < MAX_PARTS; i++)
        begin
            enabled[i] = 1'b0;
            if (i < NUM_PARTS && part_cfg[i] <= room)
            begin
                enabled[i] = 1'b1;
                room = room - part_cfg[i];
            end
        end
        if (rq.req == REQ_INSERT)
        begin
            if (rq.pid >= NUM_PROCS)
                res.status = ST_NOFIT;
            else if (proc_here[rq.pid])
            begin
                res.status = ST_PRESENT;
                res.pnum = PNUM_BITS'(proc_slot[rq.pid]) + 1'b1;
            end
            else
            begin
                // best fit over free enabled partitions; occupied ones feed
                // the fragmentation classification of a failed insert
                for (int i = 0; i < NUM_PARTS; i++)
                begin
                    if (part_busy[i])
                    begin
                        if (part_slack[i] >= rq.size)
                            covered = 1'b1;
                        else
                            small_sum = small_sum + part_slack[i];
                    end
                    else if (enabled[i] && part_cfg[i] >= rq.size
                             && (!found || part_cfg[i] < best_size))
                    begin
                        found = 1'b1;
                        best = i;
                        best_size = part_cfg[i];
                    end
                end
                if (found)
                begin
                    part_busy[best] = 1'b1;
                    part_owner[best] = rq.pid;
                    part_slack[best] = SIZE_BITS'(best_size - rq.size);
                    proc_here[rq.pid] = 1'b1;
                    proc_slot[rq.pid] = PART_BITS'(best);
                    res.status = ST_INSERTED;
                    res.pnum = PNUM_BITS'(best + 1);
                end
                else if (covered)
                    res.status = ST_INTFRAG;
                else if (rq.size <= small_sum)
                    res.status = ST_EXTFRAG;
                else
                    res.status = ST_NOFIT;
            end
        end
        else if (rq.req == REQ_DELETE)
        begin
            if (rq.pid >= NUM_PROCS || !proc_here[rq.pid])
                res.status = ST_ABSENT;
            else
            begin
                best = proc_slot[rq.pid];
                part_busy[best] = 1'b0;
                part_owner[best] = '0;
                part_slack[best] = '0;
                proc_here[rq.pid] = 1'b0;
                proc_slot[rq.pid] = '0;
                res.status = ST_DELETED;
                res.pnum = PNUM_BITS'(best + 1);
            end
        end
        else
        begin
            // report and the spare request kind
            for (int i = 0; i < MAX_PARTS; i++)
                if (part_busy[i])
                    frag_sum = frag_sum + part_slack[i];
            res.status = ST_REPORT;
            res.unused = room;
            res.frag = FRAG_BITS'(frag_sum);
        end
        return res;
    endfunction

    task automatic flag_error(input string what);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic queue_request(input logic [REQ_BITS-1:0] req,
                                 input logic [PID_BITS-1:0] pid,
                                 input logic [SIZE_BITS-1:0] size);
        alloc_req_t rq;
        rq.req = req;
        rq.pid = pid;
        rq.size = size;
        pending_requests.push_back(rq);
        n_queued++;
    endtask

    // every request transferred and every result back; nothing can be in flight
    task automatic wait_drained();
        do
            @(posedge clk);
        while (n_taken != n_queued || expected_results.size() != 0);
    endtask

    // one register per cycle; with stray set, the unmapped indexes get junk too
    task automatic program_regs(input logic [CFG_DATA_BITS-1:0] mem,
                                input logic [CFG_DATA_BITS-1:0] p0,
                                input logic [CFG_DATA_BITS-1:0] p1,
                                input logic [CFG_DATA_BITS-1:0] p2,
                                input logic [CFG_DATA_BITS-1:0] p3,
                                input bit stray);
        logic [CFG_DATA_BITS-1:0] vals [NUM_REGS];
        logic [CFG_DATA_BITS-1:0] word;
        logic [CFG_IDX_BITS-1:0]  idx;
        int                       last;
        vals[REG_MEMORY_SIZE] = mem;
        vals[REG_PART_SIZE_0] = p0;
        vals[REG_PART_SIZE_0 + 1] = p1;
        vals[REG_PART_SIZE_0 + 2] = p2;
        vals[REG_PART_SIZE_0 + 3] = p3;
        last = stray ? LAST_CFG_INDEX : NUM_REGS - 1;
        for (int k = 0; k <= last; k++)
        begin
            idx = CFG_IDX_BITS'(k);
            word = (k < NUM_REGS) ? vals[k] : CFG_DATA_BITS'($urandom);
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= word;
            if (idx == REG_MEMORY_SIZE)
                mem_cfg = word;
            else if (idx >= REG_PART_SIZE_0 && idx < REG_PART_SIZE_0 + MAX_PARTS)
                part_cfg[idx - REG_PART_SIZE_0] = word;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // request driver: holds a stalled transfer, otherwise idles for a burst
    // now and then, otherwise presents the next pending request
    always @(posedge clk)
    begin : drive_requests
        logic       nv;
        alloc_req_t rq;
        if (rst_n)
        begin
            nv = in_valid;
            if (in_valid && !in_stall)
            begin
                rq.req = req_type;
                rq.pid = process_id;
                rq.size = process_size;
                expected_results.push_back(predict_allocation(rq));
                n_taken++;
                nv = 1'b0;
                if (in_idle_rate != 0 && $urandom_range(in_idle_rate - 1, 0) == 0)
                    in_gap = $urandom_range(16, 1);
            end
            if (!nv)
            begin
                if (in_gap != 0)
                    in_gap--;
                else if (pending_requests.size() != 0)
                begin
                    rq = pending_requests.pop_front();
                    req_type <= rq.req;
                    process_id <= rq.pid;
                    process_size <= rq.size;
                    nv = 1'b1;
                end
            end
            in_valid <= nv;
        end
    end

    // result checker and receiver stall bursts
    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        logic          ns;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                flag_error($sformatf("result %0d arrived with no request behind it",
                                     n_results));
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    flag_error($sformatf("result %0d: status %0d, expected %0d",
                                         n_results, status, want.status));
                if (partition_number !== want.pnum)
                    flag_error($sformatf("result %0d: partition %0d, expected %0d",
                                         n_results, partition_number, want.pnum));
                if (unused_memory !== want.unused)
                    flag_error($sformatf("result %0d: unused memory %0d, expected %0d",
                                         n_results, unused_memory, want.unused));
                if (total_internal_frag !== want.frag)
                    flag_error($sformatf("result %0d: internal frag %0d, expected %0d",
                                         n_results, total_internal_frag, want.frag));
            end
            n_results++;
        end
        ns = 1'b0;
        if (out_gap != 0)
        begin
            out_gap--;
            ns = 1'b1;
        end
        else if (out_idle_rate != 0 && $urandom_range(out_idle_rate - 1, 0) == 0)
        begin
            out_gap = $urandom_range(16, 1) - 1;
            ns = 1'b1;
        end
        out_stall <= ns;
    end

    // watchdog: too long without a transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [CFG_DATA_BITS-1:0] mem;
        logic [CFG_DATA_BITS-1:0] s0;
        logic [CFG_DATA_BITS-1:0] s1;
        logic [CFG_DATA_BITS-1:0] s2;
        logic [CFG_DATA_BITS-1:0] s3;
        logic [SIZE_BITS-1:0]     anchor;
        logic [SIZE_BITS-1:0]     sz;
        logic [PID_BITS-1:0]      pid;
        logic [PID_BITS-1:0]      pid_base;
        logic [REQ_BITS-1:0]      req;
        int                       pick;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: every partition has size zero and all are enabled
        queue_request(REQ_INSERT, 4'd0, 16'd0);
        queue_request(REQ_INSERT, 4'd1, 16'd1);
        queue_request(REQ_REPORT, 4'd0, 16'd0);
        queue_request(REQ_DELETE, 4'd0, 16'd0);
        wait_drained();

        // 100 units split 30/20/40/10: best fit, every failed-insert class,
        // repeated insert and delete, largest size, spare request kind
        program_regs(16'd100, 16'd30, 16'd20, 16'd40, 16'd10, 1'b1);
        queue_request(REQ_REPORT, 4'd0, 16'd0);
        queue_request(REQ_INSERT, 4'd0, 16'd15);
        queue_request(REQ_INSERT, 4'd0, 16'd15);
        queue_request(REQ_INSERT, 4'd1, 16'd0);
        queue_request(REQ_INSERT, 4'd2, 16'd40);
        queue_request(REQ_INSERT, 4'd3, 16'd35);
        queue_request(REQ_INSERT, 4'd3, 16'd8);
        queue_request(REQ_INSERT, 4'd4, 16'd20);
        queue_request(REQ_INSERT, 4'd4, 16'd25);
        queue_request(REQ_INSERT, 4'd4, 16'd40);
        queue_request(REQ_DELETE, 4'd5, 16'd0);
        queue_request(REQ_DELETE, 4'd0, 16'd0);
        queue_request(REQ_DELETE, 4'd0, 16'd0);
        queue_request(REQ_INSERT, 4'd15, 16'hffff);
        queue_request(REQ_SPARE, 4'd15, 16'hffff);
        queue_request(REQ_INSERT, 4'd15, 16'd20);
        wait_drained();

        // shrink the layout under occupied partitions: two of them become
        // disabled but keep their process and leftover
        program_regs(16'hffff, 16'hffff, 16'd0, 16'd1, 16'hffff, 1'b0);
        queue_request(REQ_REPORT, 4'd0, 16'd0);
        queue_request(REQ_INSERT, 4'd7, 16'd0);
        queue_request(REQ_DELETE, 4'd3, 16'd0);
        queue_request(REQ_INSERT, 4'd8, 16'hffff);
        queue_request(REQ_DELETE, 4'd1, 16'd0);
        queue_request(REQ_INSERT, 4'd9, 16'd1);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            // layouts rotate through wide, tight, degenerate and tiny ones
            mem = CFG_DATA_BITS'($urandom);
            s0 = CFG_DATA_BITS'($urandom);
            s1 = CFG_DATA_BITS'($urandom);
            s2 = CFG_DATA_BITS'($urandom);
            s3 = CFG_DATA_BITS'($urandom);
            case (ph % 6)
                1:
                begin
                    mem = 16'hffff;
                    s0 = CFG_DATA_BITS'($urandom_range(16383, 0));
                    s1 = CFG_DATA_BITS'($urandom_range(16383, 0));
                    s2 = CFG_DATA_BITS'($urandom_range(16383, 0));
                    s3 = CFG_DATA_BITS'($urandom_range(16383, 0));
                end
                2:
                begin
                    s0 = CFG_DATA_BITS'($urandom_range(mem / 3, 0));
                    s1 = CFG_DATA_BITS'($urandom_range(mem / 3, 0));
                    s2 = CFG_DATA_BITS'($urandom_range(mem / 3, 0));
                    s3 = CFG_DATA_BITS'($urandom_range(mem / 3, 0));
                end
                3:
                begin
                    mem = '0;
                    s0 = '0;
                    s1 = '0;
                    s2 = '0;
                    s3 = '0;
                end
                4:
                begin
                    mem = 16'hffff;
                    s0 = 16'hffff;
                    s1 = 16'hffff;
                    s2 = 16'hffff;
                    s3 = 16'hffff;
                end
                5:
                begin
                    mem = CFG_DATA_BITS'($urandom_range(200, 0));
                    s0 = CFG_DATA_BITS'($urandom_range(80, 0));
                    s1 = CFG_DATA_BITS'($urandom_range(80, 0));
                    s2 = CFG_DATA_BITS'($urandom_range(80, 0));
                    s3 = CFG_DATA_BITS'($urandom_range(80, 0));
                end
                default:
                    ;
            endcase
            program_regs(mem, s0, s1, s2, s3, ph % 4 == 0);

            // idling density per phase; the closing phases run flat out
            if (ph >= RANDOM_PHASES - 2)
            begin
                in_idle_rate = 0;
                out_idle_rate = 0;
            end
            else
            begin
                pick = $urandom_range(4, 0);
                in_idle_rate = (pick == 0) ? 0 : 1 << pick;
                pick = $urandom_range(4, 0);
                out_idle_rate = (pick == 0) ? 0 : 1 << pick;
            end

            // a small window of ids per phase so deletes mostly find their process
            pid_base = PID_BITS'($urandom);
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 50)
                    req = REQ_INSERT;
                else if (pick < 80)
                    req = REQ_DELETE;
                else if (pick < 94)
                    req = REQ_REPORT;
                else
                    req = REQ_SPARE;
                if ($urandom_range(4, 0) == 0)
                    pid = PID_BITS'($urandom);
                else
                    pid = PID_BITS'(pid_base + $urandom_range(5, 0));
                // sizes cluster around the partition sizes to hit exact fits,
                // near misses and leftovers worth reusing
                anchor = part_cfg[$urandom_range(MAX_PARTS - 1, 0)];
                case ($urandom_range(9, 0))
                    0, 1:
                        sz = anchor;
                    2:
                        sz = anchor + 1'b1;
                    3, 4:
                        sz = (anchor > 16) ? anchor - SIZE_BITS'($urandom_range(16, 1))
                                           : SIZE_BITS'($urandom_range(16, 0));
                    5, 6:
                        sz = SIZE_BITS'($urandom_range(anchor, 0));
                    7:
                        sz = SIZE_BITS'($urandom_range(63, 0));
                    default:
                        sz = SIZE_BITS'($urandom);
                endcase
                queue_request(req, pid, sz);
            end
            wait_drained();
        end

        // give a stray extra result time to show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fpbf_pkg.sv
rtl/core/fpbf_ctrl.sv
rtl/core/fpbf_dp.sv
rtl/core/fixed_partition_best_fit_allocator.sv
tb/tb_fixed_partition_best_fit_allocator.sv
